// ----- src/klp_pkg.sv -----
// Shared types and constants for the key long-press detector.
// Used by klp_mul, klp_speed, key_long_press_detector and klp_checker.
// No dependencies.
package klp_pkg;

  // field widths
  localparam int DT_W     = 20;
  localparam int POS_W    = 12;
  localparam int HOLD_W   = 24;
  localparam int CMS_W    = 14;
  localparam int EDGE_W   = 13;
  localparam int MIN_DT_W = 10;
  localparam int DEF_DT_W = 20;

  // shared multiplier and comparison widths
  localparam int MUL_A_W = 34;   // cancel_speed * dt_eff fits here
  localparam int MUL_B_W = 30;   // 10^9 fits here
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RHS_W   = CMS_W + DEF_DT_W + EDGE_W;
  localparam int LHS_W   = POS_W + MUL_B_W;

  localparam logic [MUL_B_W-1:0] NS_PER_S = 30'd1000000000;

  // stream and register port widths
  localparam int IN_W   = 72;
  localparam int OUT_W  = 8;
  localparam int CLS_W  = 3;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register reset values
  localparam logic [HOLD_W-1:0]   HOLD_RST   = 24'd400000;
  localparam logic [CMS_W-1:0]    CMS_RST    = 14'd700;
  localparam logic [EDGE_W-1:0]   SW_RST     = 13'd800;
  localparam logic [EDGE_W-1:0]   SH_RST     = 13'd600;
  localparam logic [MIN_DT_W-1:0] MIN_DT_RST = 10'd10;
  localparam logic [DEF_DT_W-1:0] DEF_DT_RST = 20'd16000;

  typedef enum logic [CLS_W-1:0] {
    CLS_RELEASED,
    CLS_JUST_PRESSED,
    CLS_PRESSING,
    CLS_JUST_HELD,
    CLS_HOLDING,
    CLS_CANCELLED,
    CLS_HOLD_RELEASED,
    CLS_JUST_RELEASED
  } press_class_t;

  typedef enum logic [2:0] {
    REG_HOLD_TIME,
    REG_CANCEL_SPEED,
    REG_SCREEN_W,
    REG_SCREEN_H,
    REG_MIN_DT,
    REG_DEFAULT_DT
  } reg_idx_t;

  // input item, first field in the highest bits
  typedef struct packed {
    logic             ignore_set;
    logic             last_pointer_valid;
    logic [POS_W-1:0] last_pointer_y;
    logic [POS_W-1:0] last_pointer_x;
    logic             pointer_valid;
    logic [POS_W-1:0] pointer_y;
    logic [POS_W-1:0] pointer_x;
    logic [DT_W-1:0]  delta_time;
    logic             pressed;
  } item_t;

  typedef struct packed {
    logic [CMS_W-1:0]    cancel_speed;
    logic [EDGE_W-1:0]   screen_w;
    logic [EDGE_W-1:0]   screen_h;
    logic [MIN_DT_W-1:0] min_dt;
    logic [DEF_DT_W-1:0] default_dt;
  } spd_cfg_t;

  typedef struct packed {
    logic             start;
    logic             both_valid;
    logic [DT_W-1:0]  dt;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] lx;
    logic [POS_W-1:0] ly;
  } spd_req_t;

  typedef struct packed {
    logic done;
    logic too_fast;
  } spd_rsp_t;

endpackage

// ----- src/klp_mul.sv -----
// Shared unsigned multiplier with a registered product.
// Depends on klp_pkg for operand widths.
module klp_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [klp_pkg::MUL_A_W-1:0]  a,
  input  logic [klp_pkg::MUL_B_W-1:0]  b,
  output logic [klp_pkg::PROD_W-1:0]   prod_r
);

  logic [klp_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = klp_pkg::PROD_W'(a) * klp_pkg::PROD_W'(b);

  // product register, loaded when the sequencer issues a step
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- src/klp_speed.sv -----
// Drag speed check: a small sequencer runs three products through klp_mul
// and compares max(|dx|,|dy|)*10^9 against cancel_speed*dt_eff*edge.
// Depends on klp_pkg and klp_mul.
module klp_speed (
  input  logic                clk,
  input  logic                rst_n,
  input  klp_pkg::spd_cfg_t   cfg,
  input  klp_pkg::spd_req_t   req,
  output klp_pkg::spd_rsp_t   rsp
);

  localparam int AW   = klp_pkg::MUL_A_W;
  localparam int BW   = klp_pkg::MUL_B_W;
  localparam int RW   = klp_pkg::RHS_W;
  localparam int LW   = klp_pkg::LHS_W;
  localparam int PW   = klp_pkg::POS_W;
  localparam int DW   = klp_pkg::DT_W;
  localparam int EW   = klp_pkg::EDGE_W;

  typedef enum logic [2:0] {S_IDLE, S_M1, S_M2, S_M3, S_CMP} state_t;

  state_t          state_r, state_nxt;
  logic [PW-1:0]   dist_r;
  logic [DW-1:0]   dtef_r;
  logic [EW-1:0]   edge_r;
  logic            valid_r;
  logic [RW-1:0]   rhs_r;

  logic [PW-1:0]   dx, dy, dist_px;
  logic [DW-1:0]   dt_eff;
  logic [EW-1:0]   edge_px;
  logic            mul_en;
  logic [AW-1:0]   mul_a;
  logic [BW-1:0]   mul_b;
  logic [klp_pkg::PROD_W-1:0] prod_r;

  // operand preparation for a new request
  always_comb begin
    dx      = (req.px >= req.lx) ? req.px - req.lx : req.lx - req.px;
    dy      = (req.py >= req.ly) ? req.py - req.ly : req.ly - req.py;
    dist_px = (dx > dy) ? dx : dy;
    dt_eff  = (req.dt > DW'(cfg.min_dt)) ? req.dt : cfg.default_dt;
    edge_px = (cfg.screen_w > cfg.screen_h) ? cfg.screen_w : cfg.screen_h;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_M1: begin
        mul_en = 1'b1;
        mul_a  = AW'(cfg.cancel_speed);
        mul_b  = BW'(dtef_r);
      end
      S_M2: begin
        mul_en = 1'b1;
        mul_a  = prod_r[AW-1:0];
        mul_b  = BW'(edge_r);
      end
      S_M3: begin
        mul_en = 1'b1;
        mul_a  = AW'(dist_r);
        mul_b  = klp_pkg::NS_PER_S;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // step sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (req.start) state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_CMP;
      S_CMP:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // operand and limit registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && req.start) begin
      dist_r  <= dist_px;
      dtef_r  <= dt_eff;
      edge_r  <= edge_px;
      valid_r <= req.both_valid;
    end
    if (state_r == S_M3) begin
      rhs_r <= prod_r[RW-1:0];
    end
  end

  klp_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // the product register holds dist*10^9 during the compare step
  assign rsp.done     = (state_r == S_CMP);
  assign rsp.too_fast = valid_r && (RW'(prod_r[LW-1:0]) > rhs_r);

endmodule

// ----- src/key_long_press_detector.sv -----
// Top level of the key long-press detector: register port, press state
// machine and result register. Depends on klp_pkg and klp_speed.
//
//  port group | dir | content
//  in_*       | in  | one frame tick: key level, dt, pointer positions, ignore
//  out_*      | out | press class of that tick
//  cfg_*      | in  | register writes and reads, six registers at 4*i
//
// A request passes from acceptance to a valid result through a start step, the
// speed unit's three products on its single multiplier and its compare, and a
// classify step into the result register. in_tready is high only while idle,
// so a new request is taken only after the previous one is classified; a
// result waiting on out_tready does not block the next request, only its
// classification step. rst_n is synchronous and restores all registers to
// their defaults and clears the press state.
module key_long_press_detector #(
  parameter int TIMER_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // [0] pressed, [20:1] delta_time, [32:21] pointer_x, [44:33] pointer_y,
  // [45] pointer_valid, [57:46] last_pointer_x, [69:58] last_pointer_y,
  // [70] last_pointer_valid, [71] ignore_set
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [klp_pkg::IN_W-1:0]     in_tdata,
  // [2:0] press_class, [7:3] zero
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [klp_pkg::OUT_W-1:0]    out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [klp_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [klp_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [klp_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int TB = TIMER_BITS;
  localparam int DW = klp_pkg::DATA_W;

  typedef enum logic [1:0] {S_IDLE, S_KICK, S_WAIT, S_OUT} state_t;

  state_t                          state_r, state_nxt;
  klp_pkg::item_t                  item_r;
  logic                            fast_r;
  klp_pkg::press_class_t           cls_r, cls_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            was_pressed_r, was_pressed_nxt;
  logic                            hold_cancel_r, hold_cancel_nxt;
  logic                            ignore_r, ignore_nxt;
  logic [TB-1:0]                   timer_r, timer_nxt;

  logic [klp_pkg::HOLD_W-1:0]      hold_r;
  logic [klp_pkg::CMS_W-1:0]       cms_r;
  logic [klp_pkg::EDGE_W-1:0]      sw_r;
  logic [klp_pkg::EDGE_W-1:0]      sh_r;
  logic [klp_pkg::MIN_DT_W-1:0]    min_dt_r;
  logic [klp_pkg::DEF_DT_W-1:0]    def_dt_r;

  logic                            in_acc;
  logic                            cfg_wr;
  klp_pkg::reg_idx_t               reg_idx;
  logic                            commit;
  klp_pkg::spd_cfg_t               spd_cfg;
  klp_pkg::spd_req_t               spd_req;
  klp_pkg::spd_rsp_t               spd_rsp;

  logic [TB-1:0]                   hold_ext;
  logic [TB:0]                     timer_sum;
  logic [TB-1:0]                   timer_sat;
  logic                            held_old;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = klp_pkg::OUT_W'(cls_r);
  assign commit     = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // register port
  assign cfg_pready = 1'b1;
  assign reg_idx    = klp_pkg::reg_idx_t'(cfg_paddr[klp_pkg::ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (reg_idx)
      klp_pkg::REG_HOLD_TIME:    cfg_prdata = DW'(hold_r);
      klp_pkg::REG_CANCEL_SPEED: cfg_prdata = DW'(cms_r);
      klp_pkg::REG_SCREEN_W:     cfg_prdata = DW'(sw_r);
      klp_pkg::REG_SCREEN_H:     cfg_prdata = DW'(sh_r);
      klp_pkg::REG_MIN_DT:       cfg_prdata = DW'(min_dt_r);
      klp_pkg::REG_DEFAULT_DT:   cfg_prdata = DW'(def_dt_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= klp_pkg::HOLD_RST;
      cms_r    <= klp_pkg::CMS_RST;
      sw_r     <= klp_pkg::SW_RST;
      sh_r     <= klp_pkg::SH_RST;
      min_dt_r <= klp_pkg::MIN_DT_RST;
      def_dt_r <= klp_pkg::DEF_DT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        klp_pkg::REG_HOLD_TIME:    hold_r   <= cfg_pwdata[klp_pkg::HOLD_W-1:0];
        klp_pkg::REG_CANCEL_SPEED: cms_r    <= cfg_pwdata[klp_pkg::CMS_W-1:0];
        klp_pkg::REG_SCREEN_W:     sw_r     <= cfg_pwdata[klp_pkg::EDGE_W-1:0];
        klp_pkg::REG_SCREEN_H:     sh_r     <= cfg_pwdata[klp_pkg::EDGE_W-1:0];
        klp_pkg::REG_MIN_DT:       min_dt_r <= cfg_pwdata[klp_pkg::MIN_DT_W-1:0];
        klp_pkg::REG_DEFAULT_DT:   def_dt_r <= cfg_pwdata[klp_pkg::DEF_DT_W-1:0];
        default: ;
      endcase
    end
  end

  // speed unit hookup
  assign spd_cfg.cancel_speed = cms_r;
  assign spd_cfg.screen_w     = sw_r;
  assign spd_cfg.screen_h     = sh_r;
  assign spd_cfg.min_dt       = min_dt_r;
  assign spd_cfg.default_dt   = def_dt_r;

  assign spd_req.start      = (state_r == S_KICK);
  assign spd_req.both_valid = item_r.pointer_valid && item_r.last_pointer_valid;
  assign spd_req.dt         = item_r.delta_time;
  assign spd_req.px         = item_r.pointer_x;
  assign spd_req.py         = item_r.pointer_y;
  assign spd_req.lx         = item_r.last_pointer_x;
  assign spd_req.ly         = item_r.last_pointer_y;

  klp_speed u_speed (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (spd_cfg),
    .req   (spd_req),
    .rsp   (spd_rsp)
  );

  // saturating timer add
  assign hold_ext  = TB'(hold_r);
  assign timer_sum = {1'b0, timer_r} + (TB + 1)'(item_r.delta_time);
  assign timer_sat = timer_sum[TB] ? {TB{1'b1}} : timer_sum[TB-1:0];
  assign held_old  = (timer_r >= hold_ext);

  // press classification
  always_comb begin
    was_pressed_nxt = was_pressed_r;
    timer_nxt       = timer_r;
    cls_nxt         = klp_pkg::CLS_RELEASED;
    ignore_nxt      = ignore_r || item_r.ignore_set;
    hold_cancel_nxt = hold_cancel_r;
    if (!item_r.pressed) begin
      ignore_nxt      = 1'b0;
      hold_cancel_nxt = 1'b0;
    end
    if (!ignore_nxt) begin
      was_pressed_nxt = item_r.pressed;
      if (!item_r.pressed && !was_pressed_r) begin
        timer_nxt = '0;
        cls_nxt   = klp_pkg::CLS_RELEASED;
      end else if (item_r.pressed && !was_pressed_r) begin
        timer_nxt = '0;
        cls_nxt   = klp_pkg::CLS_JUST_PRESSED;
      end else if (item_r.pressed) begin
        if (fast_r && !hold_cancel_r) begin
          hold_cancel_nxt = 1'b1;
        end
        if (fast_r && !hold_cancel_r && held_old) begin
          cls_nxt = klp_pkg::CLS_CANCELLED;
        end else if (hold_cancel_nxt) begin
          cls_nxt = klp_pkg::CLS_PRESSING;
        end else begin
          timer_nxt = timer_sat;
          if (!held_old && timer_sat >= hold_ext) begin
            cls_nxt = klp_pkg::CLS_JUST_HELD;
          end else if (timer_sat >= hold_ext) begin
            cls_nxt = klp_pkg::CLS_HOLDING;
          end else begin
            cls_nxt = klp_pkg::CLS_PRESSING;
          end
        end
      end else begin
        cls_nxt = held_old ? klp_pkg::CLS_HOLD_RELEASED : klp_pkg::CLS_JUST_RELEASED;
      end
    end
  end

  // sequence: accept, start speed unit, wait for it, classify
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_KICK;
      S_KICK:  state_nxt = S_WAIT;
      S_WAIT:  if (spd_rsp.done) state_nxt = S_OUT;
      S_OUT:   if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state, press state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      cls_r         <= klp_pkg::CLS_RELEASED;
      was_pressed_r <= 1'b0;
      hold_cancel_r <= 1'b0;
      ignore_r      <= 1'b0;
      timer_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        cls_r         <= cls_nxt;
        was_pressed_r <= was_pressed_nxt;
        hold_cancel_r <= hold_cancel_nxt;
        ignore_r      <= ignore_nxt;
        timer_r       <= timer_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= klp_pkg::item_t'(in_tdata);
    end
    if (state_r == S_WAIT && spd_rsp.done) begin
      fast_r <= spd_rsp.too_fast;
    end
  end

endmodule

// ----- src/klp_checker.sv -----
// Port-level checks for key_long_press_detector, attached by bind.
// Depends on klp_pkg for port widths.
module klp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [klp_pkg::OUT_W-1:0] out_tdata,
  input logic                      cfg_pready
);

  // an accepted request keeps the input side busy while the speed unit runs
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input ready during speed computation");

  // a request accepted while no result is pending brings no early result
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid) |=> !out_tvalid ##1 !out_tvalid)
    else $error("result appeared too early");

  // class field only, padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[klp_pkg::OUT_W-1:klp_pkg::CLS_W] == '0))
    else $error("result padding not zero");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // register port never waits
  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind key_long_press_detector klp_checker u_klp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
